// File: src/ttpr_pkg.sv
`timescale 1ns / 1ps

package ttpr_pkg;

   localparam int CSR_INDEX_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_THRESHOLD      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_THRESHOLD     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAN_MATE_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAN_LOSS_THRESHOLD = 8'd3;

   localparam logic signed [15:0] WIN_THRESHOLD_RESET      = 16'sd9500;
   localparam logic signed [15:0] LOST_THRESHOLD_RESET     = -16'sd9500;
   localparam logic signed [15:0] BAN_MATE_THRESHOLD_RESET = 16'sd9800;
   localparam logic signed [15:0] BAN_LOSS_THRESHOLD_RESET = -16'sd9800;

   localparam logic CMD_PROBE  = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

endpackage

// File: src/transposition_table_probe_record_unit.sv
`timescale 1ns / 1ps
// Direct-mapped transposition table with depth-preferred replacement.
// Request channel (req_valid / req_stall): one probe or record per word.
// req_command selects probe or record; the low INDEX_BITS of the position
// key pick the slot, the full key is stored and compared.
// Response channel (rsp_valid / rsp_stall): one word per request. A probe
// returns the stored move on a key match and a distance-adjusted score when
// the depth and window tests pass; a record reports whether it wrote.
// Configuration (csr_valid / csr_ready): four signed 16-bit thresholds,
// always ready; the user must see that they are written only while the
// table is idle, the block does not enforce it. A request is read from
// the table, then walks 8 steps through one shared 17-bit add/compare
// unit, then finishes; the next request is taken back in the idle state.
// Reset starts a clearing pass that zeroes all 2**INDEX_BITS slots;
// req_stall stays high during it. If the response is still stalled
// when the next request finishes, that request waits in its finish state
// until the response register frees up; a stalled response holds its value.
module transposition_table_probe_record_unit #(
   parameter int INDEX_BITS = 12,
   parameter int MOVE_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [63:0]                     req_position_key,
   input  logic [7:0]                      req_ply_distance,
   input  logic signed [15:0]              req_alpha_bound,
   input  logic signed [15:0]              req_beta_bound,
   input  logic signed [7:0]               req_search_depth,
   input  logic [1:0]                      req_bound_kind,
   input  logic signed [15:0]              req_new_score,
   input  logic [15:0]                     req_new_move,
   input  logic                            req_new_move_valid,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_score_hit,
   output logic signed [15:0]              rsp_hit_score,
   output logic                            rsp_move_found,
   output logic [15:0]                     rsp_found_move,
   output logic                            rsp_written,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ttpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);
   import ttpr_pkg::*;

   localparam int SLOT_COUNT = 1 << INDEX_BITS;
   localparam int KIND_LSB   = 0;
   localparam int DEPTH_LSB  = 2;
   localparam int SCORE_LSB  = 10;
   localparam int MOVE_LSB   = 26;
   localparam int KEY_LSB    = MOVE_LSB + MOVE_BITS;
   localparam int ENTRY_W    = KEY_LSB + 64;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      STEP_WIN,
      STEP_LOST,
      STEP_BAN_MATE,
      STEP_BAN_LOSS,
      STEP_ADJUST,
      STEP_DEPTH,
      STEP_BETA,
      STEP_ALPHA
   } step_type;

   state_type state_ff;
   step_type  step_ff;
   logic [INDEX_BITS-1:0] clr_cnt_ff;

   logic signed [15:0] win_ff, lost_ff, ban_mate_ff, ban_loss_ff;

   // captured request
   logic                command_ff;
   logic [63:0]         key_ff;
   logic [7:0]          dist_ff;
   logic signed [15:0]  alpha_ff, beta_ff, new_score_ff;
   logic signed [7:0]   depth_ff;
   logic [1:0]          kind_ff;
   logic [15:0]         new_move_ff;
   logic                move_valid_ff;

   // flags from the shared unit
   logic gt_win_ff, lt_lost_ff;
   logic banm_lt_ff, banm_eq_ff, banl_lt_ff, banl_eq_ff;
   logic depth_lt_ff, depth_eq_ff;
   logic ge_beta_ff, le_alpha_ff;
   logic signed [15:0] adj_ff;

   logic                rsp_valid_ff, rsp_score_hit_ff, rsp_move_found_ff, rsp_written_ff;
   logic signed [15:0]  rsp_hit_score_ff;
   logic [15:0]         rsp_found_move_ff;

   logic [ENTRY_W-1:0]  mem [SLOT_COUNT];
   logic [ENTRY_W-1:0]  rd_entry_ff;
   logic                mem_we;
   logic [INDEX_BITS-1:0] mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [INDEX_BITS-1:0] index;

   logic [63:0]          rd_key;
   logic [MOVE_BITS-1:0] rd_move;
   logic signed [15:0]   rd_score;
   logic signed [7:0]    rd_depth;
   logic [1:0]           rd_kind;

   logic signed [15:0]  alu_a, alu_b;
   logic                alu_sub;
   logic [16:0]         alu_res;
   logic                alu_lt, alu_eq;
   logic signed [15:0]  score_sel;

   logic [MOVE_BITS+15:0] move_in_ext, move_out_ext;
   logic                key_match, probe_banned, probe_mate, depth_ok, bound_ok, probe_hit;
   logic signed [15:0]  probe_score, record_score;
   logic                record_skip, record_drop, record_keep;
   logic                rsp_free, finish_go;

   assign index     = key_ff[INDEX_BITS-1:0];
   assign rd_key    = rd_entry_ff[KEY_LSB +: 64];
   assign rd_move   = rd_entry_ff[MOVE_LSB +: MOVE_BITS];
   assign rd_score  = rd_entry_ff[SCORE_LSB +: 16];
   assign rd_depth  = rd_entry_ff[DEPTH_LSB +: 8];
   assign rd_kind   = rd_entry_ff[KIND_LSB +: 2];

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score_hit  = rsp_score_hit_ff;
   assign rsp_hit_score  = rsp_hit_score_ff;
   assign rsp_move_found = rsp_move_found_ff;
   assign rsp_found_move = rsp_found_move_ff;
   assign rsp_written    = rsp_written_ff;

   // shared 17-bit add/compare unit
   assign score_sel = (command_ff == CMD_RECORD) ? new_score_ff : rd_score;

   always_comb begin
      alu_a   = score_sel;
      alu_b   = win_ff;
      alu_sub = 1'b1;
      unique case (step_ff)
         STEP_WIN:      alu_b = win_ff;
         STEP_LOST:     alu_b = lost_ff;
         STEP_BAN_MATE: alu_b = ban_mate_ff;
         STEP_BAN_LOSS: alu_b = ban_loss_ff;
         STEP_ADJUST: begin
            // probe removes distance from winning mates, record adds it
            alu_b   = {8'b0, dist_ff};
            alu_sub = gt_win_ff ^ (command_ff == CMD_RECORD);
         end
         STEP_DEPTH: begin
            alu_a = {{8{rd_depth[7]}}, rd_depth};
            alu_b = {{8{depth_ff[7]}}, depth_ff};
         end
         STEP_BETA: begin
            alu_a = probe_score;
            alu_b = beta_ff;
         end
         STEP_ALPHA: begin
            alu_a = probe_score;
            alu_b = alpha_ff;
         end
      endcase
   end

   assign alu_res = alu_sub ? ({alu_a[15], alu_a} - {alu_b[15], alu_b})
                            : ({alu_a[15], alu_a} + {alu_b[15], alu_b});
   assign alu_lt  = alu_res[16];
   assign alu_eq  = (alu_res == 17'd0);

   // result evaluation
   assign key_match    = (rd_key == key_ff);
   assign probe_banned = gt_win_ff ? banm_lt_ff : (lt_lost_ff & ~banl_lt_ff & ~banl_eq_ff);
   assign probe_mate   = gt_win_ff ? ~banm_lt_ff : (lt_lost_ff & (banl_lt_ff | banl_eq_ff));
   assign probe_score  = probe_mate ? adj_ff : rd_score;
   assign depth_ok     = ~depth_lt_ff | probe_mate;

   always_comb begin
      unique case (rd_kind)
         BOUND_LOWER: bound_ok = ge_beta_ff;
         BOUND_UPPER: bound_ok = le_alpha_ff;
         default:     bound_ok = 1'b1;
      endcase
   end

   assign probe_hit = key_match & ~probe_banned & depth_ok & bound_ok;

   assign record_skip  = ~depth_lt_ff & ~depth_eq_ff;
   assign record_drop  = gt_win_ff ? (~move_valid_ff & (banm_lt_ff | banm_eq_ff))
                                   : (lt_lost_ff & ~move_valid_ff & ~banl_lt_ff);
   assign record_keep  = ~record_skip & ~record_drop;
   assign record_score = (gt_win_ff | lt_lost_ff) ? adj_ff : new_score_ff;

   assign move_in_ext  = {{MOVE_BITS{1'b0}}, new_move_ff};
   assign move_out_ext = {16'b0, rd_move};

   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign finish_go = (state_ff == ST_FINISH) & rsp_free;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = index;
      mem_wdata = {key_ff, move_in_ext[MOVE_BITS-1:0], record_score, depth_ff, kind_ff};
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (finish_go && command_ff == CMD_RECORD && record_keep) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_entry_ff <= mem[index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= WIN_THRESHOLD_RESET;
         lost_ff     <= LOST_THRESHOLD_RESET;
         ban_mate_ff <= BAN_MATE_THRESHOLD_RESET;
         ban_loss_ff <= BAN_LOSS_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIN_THRESHOLD:      win_ff      <= csr_wdata;
            CSR_LOST_THRESHOLD:     lost_ff     <= csr_wdata;
            CSR_BAN_MATE_THRESHOLD: ban_mate_ff <= csr_wdata;
            CSR_BAN_LOSS_THRESHOLD: ban_loss_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture and step flags
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         command_ff    <= req_command;
         key_ff        <= req_position_key;
         dist_ff       <= req_ply_distance;
         alpha_ff      <= req_alpha_bound;
         beta_ff       <= req_beta_bound;
         depth_ff      <= req_search_depth;
         kind_ff       <= req_bound_kind;
         new_score_ff  <= req_new_score;
         new_move_ff   <= req_new_move;
         move_valid_ff <= req_new_move_valid;
      end
      if (state_ff == ST_STEP) begin
         unique case (step_ff)
            STEP_WIN:      gt_win_ff  <= ~alu_lt & ~alu_eq;
            STEP_LOST:     lt_lost_ff <= alu_lt;
            STEP_BAN_MATE: begin
               banm_lt_ff <= alu_lt;
               banm_eq_ff <= alu_eq;
            end
            STEP_BAN_LOSS: begin
               banl_lt_ff <= alu_lt;
               banl_eq_ff <= alu_eq;
            end
            STEP_ADJUST:   adj_ff <= alu_res[15:0];
            STEP_DEPTH: begin
               depth_lt_ff <= alu_lt;
               depth_eq_ff <= alu_eq;
            end
            STEP_BETA:     ge_beta_ff  <= ~alu_lt;
            STEP_ALPHA:    le_alpha_ff <= alu_lt | alu_eq;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_WIN;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (&clr_cnt_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               step_ff  <= STEP_WIN;
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (step_ff == STEP_ALPHA) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_type'(step_ff + 3'd1);
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
                  if (command_ff == CMD_RECORD) begin
                     rsp_score_hit_ff  <= 1'b0;
                     rsp_hit_score_ff  <= '0;
                     rsp_move_found_ff <= 1'b0;
                     rsp_found_move_ff <= '0;
                     rsp_written_ff    <= record_keep;
                  end else begin
                     rsp_score_hit_ff  <= probe_hit;
                     rsp_hit_score_ff  <= probe_hit ? probe_score : 16'sd0;
                     rsp_move_found_ff <= key_match;
                     rsp_found_move_ff <= key_match ? move_out_ext[15:0] : 16'd0;
                     rsp_written_ff    <= 1'b0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: src/ttpr_checker.sv
`timescale 1ns / 1ps

module ttpr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_score_hit,
   input logic signed [15:0]               rsp_hit_score,
   input logic                             rsp_move_found,
   input logic [15:0]                      rsp_found_move,
   input logic                             rsp_written
);
   import ttpr_pkg::*;

   // the clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open while a request is in flight");

   // a record word carries no probe result
   a_record_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> !rsp_score_hit && !rsp_move_found)
      else $error("written word carries a probe result");

   // a score hit needs a key match, and misses read as zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_move_found |->
         !rsp_score_hit && rsp_found_move == 16'd0 && rsp_hit_score == 16'sd0)
      else $error("miss word with nonzero fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_hit_score) && $stable(rsp_found_move))
      else $error("stalled response word changed");

endmodule

bind transposition_table_probe_record_unit ttpr_checker u_ttpr_checker (.*);

// File: tb/sv/tb_transposition_table_probe_record_unit.sv
`timescale 1ns / 1ps

module tb_transposition_table_probe_record_unit;
   import ttpr_pkg::*;

   localparam int INDEX_BITS       = 12;
   localparam int MOVE_BITS        = 16;
   localparam int TABLE_SLOTS      = 1 << INDEX_BITS;
   localparam int WATCHDOG_LIMIT   = 4 * TABLE_SLOTS;
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 226;
   localparam int SETTLE_CYCLES    = 12;

   typedef struct {
      logic               command;
      logic [63:0]        key;
      logic [7:0]         ply;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic signed [7:0]  depth;
      logic [1:0]         kind;
      logic signed [15:0] score;
      logic [15:0]        move;
      logic               move_valid;
   } tt_request_t;

   typedef struct {
      logic               score_hit;
      logic signed [15:0] hit_score;
      logic               move_found;
      logic [15:0]        found_move;
      logic               written;
   } tt_answer_t;

   // shadow copy of the table plus the queue of answers still owed by the block
   class tt_table_model;
      logic [63:0] slot_key [TABLE_SLOTS];
      logic [15:0] slot_move [TABLE_SLOTS];
      int          slot_score [TABLE_SLOTS];
      int          slot_depth [TABLE_SLOTS];
      logic [1:0]  slot_kind [TABLE_SLOTS];
      int          win_limit;
      int          lost_limit;
      int          ban_win_limit;
      int          ban_loss_limit;
      tt_answer_t  owed_answers [$];
      int          mismatches;
      int          probes;
      int          records;
      int          score_hits;
      int          writes;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]   = '0;
            slot_move[i]  = '0;
            slot_score[i] = 0;
            slot_depth[i] = 0;
            slot_kind[i]  = BOUND_EXACT;
         end
         win_limit      = WIN_THRESHOLD_RESET;
         lost_limit     = LOST_THRESHOLD_RESET;
         ban_win_limit  = BAN_MATE_THRESHOLD_RESET;
         ban_loss_limit = BAN_LOSS_THRESHOLD_RESET;
      endfunction

      function int fold16(int x);
         logic signed [15:0] t;
         t = x[15:0];
         return int'(t);
      endfunction

      function int pending();
         return owed_answers.size();
      endfunction

      function void set_threshold(logic [CSR_INDEX_W-1:0] idx, logic signed [15:0] val);
         case (idx)
            CSR_WIN_THRESHOLD:      win_limit = val;
            CSR_LOST_THRESHOLD:     lost_limit = val;
            CSR_BAN_MATE_THRESHOLD: ban_win_limit = val;
            CSR_BAN_LOSS_THRESHOLD: ban_loss_limit = val;
            default: ;
         endcase
      endfunction

      function void note_request(tt_request_t r);
         tt_answer_t a;
         int         idx;
         int         sc;
         int         stored;
         int         ply_dist;
         bit         mate;
         bit         banned;
         bit         ok;
         bit         keep;
         a        = '{default: '0};
         idx      = int'(r.key[INDEX_BITS-1:0]);
         ply_dist = int'(r.ply);
         mate     = 1'b0;
         banned   = 1'b0;
         if (r.command == CMD_PROBE) begin
            probes++;
            if (slot_key[idx] == r.key) begin
               a.move_found = 1'b1;
               a.found_move = slot_move[idx];
               sc = slot_score[idx];
               if (sc > win_limit) begin
                  if (sc < ban_win_limit) banned = 1'b1;
                  else begin
                     mate = 1'b1;
                     sc = fold16(sc - ply_dist);
                  end
               end else if (sc < lost_limit) begin
                  if (sc > ban_loss_limit) banned = 1'b1;
                  else begin
                     mate = 1'b1;
                     sc = fold16(sc + ply_dist);
                  end
               end
               if (!banned && (slot_depth[idx] >= int'(r.depth) || mate)) begin
                  case (slot_kind[idx])
                     BOUND_LOWER: ok = (sc >= int'(r.beta));
                     BOUND_UPPER: ok = (sc <= int'(r.alpha));
                     default:     ok = 1'b1;
                  endcase
                  if (ok) begin
                     a.score_hit = 1'b1;
                     a.hit_score = sc[15:0];
                  end
               end
            end
         end else begin
            records++;
            sc     = int'(r.score);
            stored = sc;
            keep   = 1'b1;
            // depth-preferred: a deeper entry stays put
            if (slot_depth[idx] > int'(r.depth)) keep = 1'b0;
            else if (sc > win_limit) begin
               if (!r.move_valid && sc <= ban_win_limit) keep = 1'b0;
               else stored = fold16(sc + ply_dist);
            end else if (sc < lost_limit) begin
               if (!r.move_valid && sc >= ban_loss_limit) keep = 1'b0;
               else stored = fold16(sc - ply_dist);
            end
            if (keep) begin
               slot_key[idx]   = r.key;
               slot_move[idx]  = r.move[MOVE_BITS-1:0];
               slot_score[idx] = stored;
               slot_depth[idx] = int'(r.depth);
               slot_kind[idx]  = r.kind;
               a.written       = 1'b1;
            end
         end
         owed_answers.push_back(a);
      endfunction

      function void flag(string field, int want, int got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_response(tt_answer_t got);
         tt_answer_t want;
         if (owed_answers.size() == 0) begin
            mismatches++;
            $display("%0t: response word with no request outstanding", $time);
            return;
         end
         want = owed_answers.pop_front();
         if (want.score_hit) score_hits++;
         if (want.written) writes++;
         if (got.score_hit !== want.score_hit)
            flag("score_hit", want.score_hit, got.score_hit);
         if (got.hit_score !== want.hit_score)
            flag("hit_score", want.hit_score, got.hit_score);
         if (got.move_found !== want.move_found)
            flag("move_found", want.move_found, got.move_found);
         if (got.found_move !== want.found_move)
            flag("found_move", want.found_move, got.found_move);
         if (got.written !== want.written)
            flag("written", want.written, got.written);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_command;
   logic [63:0]            req_position_key;
   logic [7:0]             req_ply_distance;
   logic signed [15:0]     req_alpha_bound;
   logic signed [15:0]     req_beta_bound;
   logic signed [7:0]      req_search_depth;
   logic [1:0]             req_bound_kind;
   logic signed [15:0]     req_new_score;
   logic [15:0]            req_new_move;
   logic                   req_new_move_valid;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_score_hit;
   logic signed [15:0]     rsp_hit_score;
   logic                   rsp_move_found;
   logic [15:0]            rsp_found_move;
   logic                   rsp_written;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0]            csr_wdata;

   tt_table_model          tt;
   tt_request_t            seen_request;
   tt_answer_t             seen_answer;
   int                     quiet_cycles;
   int                     idle_pct;
   int                     stall_pct;
   logic [INDEX_BITS-1:0]  key_index [8];
   logic [63-INDEX_BITS:0] key_upper [4];

   // phase 0 runs on the reset values, the rest are written before their phase
   logic signed [15:0] phase_limits [PHASES][4] = '{
      '{16'sd9500, -16'sd9500, 16'sd9800, -16'sd9800},
      '{16'sd200, -16'sd200, 16'sd600, -16'sd600},
      '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
      '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
      '{16'sd9500, -16'sd9500, 16'sd9000, -16'sd9000}
   };

   transposition_table_probe_record_unit #(
      .INDEX_BITS(INDEX_BITS),
      .MOVE_BITS (MOVE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_position_key  (req_position_key),
      .req_ply_distance  (req_ply_distance),
      .req_alpha_bound   (req_alpha_bound),
      .req_beta_bound    (req_beta_bound),
      .req_search_depth  (req_search_depth),
      .req_bound_kind    (req_bound_kind),
      .req_new_score     (req_new_score),
      .req_new_move      (req_new_move),
      .req_new_move_valid(req_new_move_valid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_score_hit     (rsp_score_hit),
      .rsp_hit_score     (rsp_hit_score),
      .rsp_move_found    (rsp_move_found),
      .rsp_found_move    (rsp_found_move),
      .rsp_written       (rsp_written),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // sample both channels before the edge updates anything
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_answer = '{rsp_score_hit, rsp_hit_score, rsp_move_found,
                            rsp_found_move, rsp_written};
            tt.check_response(seen_answer);
         end
         if (req_valid && !req_stall) begin
            seen_request = '{req_command, req_position_key, req_ply_distance,
                             req_alpha_bound, req_beta_bound, req_search_depth,
                             req_bound_kind, req_new_score, req_new_move,
                             req_new_move_valid};
            tt.note_request(seen_request);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL transposition_table_probe_record_unit");
            $finish;
         end
      end
   end

   function automatic tt_request_t req_of(logic cmd, logic [63:0] key, int ply, int alpha,
                                          int beta, int depth, logic [1:0] kind,
                                          int score, int move, logic move_valid);
      tt_request_t r;
      r = '{cmd, key, 8'(ply), 16'(alpha), 16'(beta), 8'(depth), kind, 16'(score),
            16'(move), move_valid};
      return r;
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(9) == 0) return {$urandom, $urandom};
      return {key_upper[$urandom_range(3)], key_index[$urandom_range(7)]};
   endfunction

   // scores cluster around the current thresholds so mate and ban bands get hit
   function automatic logic signed [15:0] pick_score();
      case ($urandom_range(6))
         0: return 16'(tt.win_limit + int'($urandom_range(600)));
         1: return 16'(tt.lost_limit - int'($urandom_range(600)));
         2: return 16'(tt.ban_win_limit + int'($urandom_range(16)) - 8);
         3: return 16'(tt.ban_loss_limit + int'($urandom_range(16)) - 8);
         4: return 16'(int'($urandom_range(400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tt_request_t random_request();
      tt_request_t r;
      r.command    = ($urandom_range(1) == 1) ? CMD_RECORD : CMD_PROBE;
      r.key        = pick_key();
      r.ply        = ($urandom_range(1) == 1) ? 8'($urandom_range(20)) : 8'($urandom);
      r.alpha      = pick_score();
      r.beta       = pick_score();
      // deep records are rare so the pooled slots keep taking new entries
      if (r.command == CMD_RECORD)
         r.depth = ($urandom_range(29) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      else
         r.depth = ($urandom_range(4) == 0) ? 8'($urandom) : 8'(int'($urandom_range(12)) - 2);
      r.kind       = 2'($urandom_range(3));
      r.score      = pick_score();
      r.move       = 16'($urandom);
      r.move_valid = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic offer_request(input tt_request_t r);
      req_valid          <= 1'b1;
      req_command        <= r.command;
      req_position_key   <= r.key;
      req_ply_distance   <= r.ply;
      req_alpha_bound    <= r.alpha;
      req_beta_bound     <= r.beta;
      req_search_depth   <= r.depth;
      req_bound_kind     <= r.kind;
      req_new_score      <= r.score;
      req_new_move       <= r.move;
      req_new_move_valid <= r.move_valid;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(24, 1)) @(negedge clock);
      end
   endtask

   task automatic wait_until_idle();
      while (tt.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_thresholds(input logic signed [15:0] limits [4]);
      logic [CSR_INDEX_W-1:0] regs [4] = '{CSR_WIN_THRESHOLD, CSR_LOST_THRESHOLD,
                                           CSR_BAN_MATE_THRESHOLD, CSR_BAN_LOSS_THRESHOLD};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= limits[i];
         do @(posedge clock); while (!csr_ready);
         tt.set_threshold(regs[i], limits[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      tt_request_t directed [$];
      logic [63:0] k1;
      logic [63:0] k2;
      logic [63:0] k3;
      logic [63:0] kmax;

      tt                 = new();
      quiet_cycles       = 0;
      idle_pct           = 0;
      stall_pct          = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_PROBE;
      req_position_key   = '0;
      req_ply_distance   = '0;
      req_alpha_bound    = '0;
      req_beta_bound     = '0;
      req_search_depth   = '0;
      req_bound_kind     = BOUND_EXACT;
      req_new_score      = '0;
      req_new_move       = '0;
      req_new_move_valid = 1'b0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = CSR_WIN_THRESHOLD;
      csr_wdata          = '0;

      k1   = 64'h0123_4567_89ab_c005;
      k2   = 64'hffff_ffff_ffff_f005;
      k3   = 64'h8000_0000_0000_0007;
      kmax = '1;
      // untouched slot with key zero, then mates, ban bands, bounds and wrapping
      directed.push_back(req_of(CMD_PROBE, 64'd0, 0, -32768, 32767, -128, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_PROBE, 64'd0, 0, 0, 0, 1, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_PROBE, k1, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, k1, 0, 0, 0, 5, BOUND_EXACT, 100, 16'hffff, 1));
      directed.push_back(req_of(CMD_PROBE, k1, 0, 0, 0, 5, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_PROBE, k2, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, k1, 0, 0, 0, 3, BOUND_EXACT, 200, 1, 1));
      directed.push_back(req_of(CMD_RECORD, k1, 10, 0, 0, 6, BOUND_EXACT, 10000, 2, 1));
      directed.push_back(req_of(CMD_PROBE, k1, 20, 0, 0, 127, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, k1, 0, 0, 0, 6, BOUND_EXACT, 9600, 3, 0));
      directed.push_back(req_of(CMD_RECORD, k1, 50, 0, 0, 6, BOUND_EXACT, 9600, 4, 1));
      directed.push_back(req_of(CMD_PROBE, k1, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, k1, 3, 0, 0, 7, BOUND_LOWER, -10000, 5, 0));
      directed.push_back(req_of(CMD_PROBE, k1, 3, 0, -10000, 0, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_PROBE, k1, 3, 0, -9999, 0, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, kmax, 255, 0, 0, 127, BOUND_UPPER, 32767, 0, 1));
      directed.push_back(req_of(CMD_PROBE, kmax, 255, 32767, 0, 127, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_PROBE, kmax, 255, -32768, 0, 127, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, kmax, 0, 0, 0, -128, BOUND_EXACT, 0, 7, 1));
      directed.push_back(req_of(CMD_RECORD, k3, 255, 0, 0, -128, 2'd3, -32768, 16'h5a5a, 0));
      directed.push_back(req_of(CMD_PROBE, k3, 255, -32768, 32767, -128, BOUND_EXACT, 0, 0, 0));
      directed.push_back(req_of(CMD_RECORD, k3, 0, 0, 0, 0, BOUND_EXACT, -9700, 9, 0));
      directed.push_back(req_of(CMD_PROBE, k3, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            wait_until_idle();
            write_thresholds(phase_limits[p]);
         end
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         foreach (key_index[i]) key_index[i] = INDEX_BITS'($urandom);
         foreach (key_upper[i]) key_upper[i] = (64-INDEX_BITS)'({$urandom, $urandom});
         key_index[0] = '0;
         key_upper[0] = '0;
         if (p == 0) foreach (directed[i]) offer_request(directed[i]);
         repeat (RANDOM_PER_PHASE) offer_request(random_request());
      end
      req_valid <= 1'b0;
      wait_until_idle();

      $display("run covered %0d probes (%0d score hits) and %0d records (%0d written)",
               tt.probes, tt.score_hits, tt.records, tt.writes);
      $display("over %0d threshold settings with sender gaps and response stalls, %0d mismatches",
               PHASES, tt.mismatches);
      if (tt.mismatches == 0 && tt.pending() == 0)
         $display("PASS transposition_table_probe_record_unit");
      else
         $display("FAIL transposition_table_probe_record_unit");
      $finish;
   end

endmodule

// File: sim.f
src/ttpr_pkg.sv
src/transposition_table_probe_record_unit.sv
src/ttpr_checker.sv
tb/sv/tb_transposition_table_probe_record_unit.sv
